@@ hdl/iphx_pkg.sv @@
// Package for the IPv4 / L4 header extractor.
// Holds header sizes, protocol numbers, status codes and the result record.
// No dependencies.
package iphx_pkg;

	localparam int unsigned OFF_W = 7;
	localparam int unsigned TDATA_W = 304;

	localparam logic [OFF_W-1:0] ETH_HDR_BYTES = 7'd14;
	localparam logic [7:0] IP_MIN_BYTES = 8'd20;
	localparam logic [7:0] TCP_MIN_BYTES = 8'd20;
	localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT_ETH = 3'd1;
	localparam logic [2:0] ST_SHORT_IP = 3'd2;
	localparam logic [2:0] ST_SHORT_OPT = 3'd3;
	localparam logic [2:0] ST_NOT_L4 = 3'd4;
	localparam logic [2:0] ST_SHORT_L4 = 3'd5;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] ip_ident;
		logic [7:0]  protocol;
		logic [31:0] port_pair;
		logic [31:0] tcp_seq;
		logic [31:0] tcp_ack;
		logic [7:0]  tcp_flags;
		logic [15:0] payload_len;
	} res_t;

endpackage

@@ hdl/iphx_parse.sv @@
// Per-frame header state: byte offset, captured header fields, end-of-frame checks.
// Depends on iphx_pkg.
module iphx_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              eth_present,
	output iphx_pkg::res_t    res
);

	logic [6:0]  off_q;
	logic [47:0] dmac_q, smac_q, dmac_n, smac_n;
	logic [31:0] sip_q, dip_q, sip_n, dip_n;
	logic [15:0] ident_q, ident_n, tlen_q, tlen_n, udp_q, udp_n;
	logic [7:0]  proto_q, proto_n, flags_q, flags_n;
	logic [3:0]  hw_q, hw_n, doff_q, doff_n;
	logic [31:0] ports_q, ports_n, seq_q, seq_n, ack_q, ack_n;

	logic [6:0]  eth, q, r;
	logic        in_eth;
	logic [5:0]  ihl;
	logic [7:0]  len, iplen, l4len;
	logic [6:0]  sub;
	logic [15:0] tcp_pay, udp_pay;

	always_comb begin
		eth = eth_present ? iphx_pkg::ETH_HDR_BYTES : 7'd0;
		in_eth = eth_present && (off_q < iphx_pkg::ETH_HDR_BYTES);
		q = off_q - eth;
		dmac_n = dmac_q; smac_n = smac_q; sip_n = sip_q; dip_n = dip_q;
		ident_n = ident_q; tlen_n = tlen_q; udp_n = udp_q; proto_n = proto_q;
		flags_n = flags_q; hw_n = hw_q; doff_n = doff_q;
		ports_n = ports_q; seq_n = seq_q; ack_n = ack_q;
		ihl = {hw_q, 2'b00};
		r = 7'd0;
		if (in_eth) begin
			if (off_q < 7'd6)
				dmac_n = {dmac_q[39:0], data_byte};
			else if (off_q < 7'd12)
				smac_n = {smac_q[39:0], data_byte};
		end else begin
			case (q) inside
				7'd0: hw_n = data_byte[3:0];
				7'd2, 7'd3: tlen_n = {tlen_q[7:0], data_byte};
				7'd4, 7'd5: ident_n = {ident_q[7:0], data_byte};
				7'd9: proto_n = data_byte;
				[7'd12:7'd15]: sip_n = {sip_q[23:0], data_byte};
				[7'd16:7'd19]: dip_n = {dip_q[23:0], data_byte};
				default: ;
			endcase
			ihl = {hw_n, 2'b00};
			if (q >= {1'b0, ihl}) begin
				r = q - {1'b0, ihl};
				if (r < 7'd4)
					ports_n = {ports_q[23:0], data_byte};
				else if (r < 7'd8)
					seq_n = {seq_q[23:0], data_byte};
				else if (r < 7'd12)
					ack_n = {ack_q[23:0], data_byte};
				else if (r == 7'd12)
					doff_n = data_byte[7:4];
				else if (r == 7'd13)
					flags_n = data_byte;
				if (r == 7'd4 || r == 7'd5)
					udp_n = {udp_q[7:0], data_byte};
			end
		end
	end

	always_comb begin
		len = {1'b0, off_q} + 8'd1;
		iplen = len - {1'b0, eth};
		l4len = iplen - {2'b00, ihl};
		sub = {1'b0, ihl} + {1'b0, doff_n, 2'b00};
		tcp_pay = (tlen_n > {9'd0, sub}) ? tlen_n - {9'd0, sub} : 16'd0;
		udp_pay = (udp_n > {8'd0, iphx_pkg::UDP_HDR_BYTES}) ?
			udp_n - {8'd0, iphx_pkg::UDP_HDR_BYTES} : 16'd0;
		res = '0;
		if (len < {1'b0, eth}) begin
			res.status = iphx_pkg::ST_SHORT_ETH;
		end else begin
			if (eth_present) begin
				res.dst_mac = dmac_n;
				res.src_mac = smac_n;
			end
			if (iplen < iphx_pkg::IP_MIN_BYTES) begin
				res.status = iphx_pkg::ST_SHORT_IP;
			end else if (iplen < {2'b00, ihl}) begin
				res.status = iphx_pkg::ST_SHORT_OPT;
			end else begin
				res.src_ip = sip_n;
				res.dst_ip = dip_n;
				res.ip_ident = ident_n;
				res.protocol = proto_n;
				if (proto_n == iphx_pkg::PROTO_TCP) begin
					if (l4len < iphx_pkg::TCP_MIN_BYTES) begin
						res.status = iphx_pkg::ST_SHORT_L4;
					end else begin
						res.status = iphx_pkg::ST_OK;
						res.port_pair = ports_n;
						res.tcp_seq = seq_n;
						res.tcp_ack = ack_n;
						res.tcp_flags = flags_n;
						res.payload_len = tcp_pay;
					end
				end else if (proto_n == iphx_pkg::PROTO_UDP) begin
					if (l4len < iphx_pkg::UDP_HDR_BYTES) begin
						res.status = iphx_pkg::ST_SHORT_L4;
					end else begin
						res.status = iphx_pkg::ST_OK;
						res.port_pair = ports_n;
						res.payload_len = udp_pay;
					end
				end else begin
					res.status = iphx_pkg::ST_NOT_L4;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; dmac_q <= '0; smac_q <= '0; sip_q <= '0; dip_q <= '0;
			ident_q <= '0; tlen_q <= '0; udp_q <= '0; proto_q <= '0;
			flags_q <= '0; hw_q <= '0; doff_q <= '0;
			ports_q <= '0; seq_q <= '0; ack_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				off_q <= '0; dmac_q <= '0; smac_q <= '0; sip_q <= '0; dip_q <= '0;
				ident_q <= '0; tlen_q <= '0; udp_q <= '0; proto_q <= '0;
				flags_q <= '0; hw_q <= '0; doff_q <= '0;
				ports_q <= '0; seq_q <= '0; ack_q <= '0;
			end else begin
				if (!(&off_q))
					off_q <= off_q + 7'd1;
				dmac_q <= dmac_n; smac_q <= smac_n; sip_q <= sip_n; dip_q <= dip_n;
				ident_q <= ident_n; tlen_q <= tlen_n; udp_q <= udp_n;
				proto_q <= proto_n; flags_q <= flags_n; hw_q <= hw_n;
				doff_q <= doff_n; ports_q <= ports_n; seq_q <= seq_n; ack_q <= ack_n;
			end
		end
	end

endmodule

@@ hdl/ipv4_l4_header_extractor_unit.sv @@
// Top level of the IPv4 / L4 header extractor: input register, header state, result register.
// Depends on iphx_pkg and iphx_parse.
//
// Usage:
//   s_* carries one captured frame byte per transaction, s_tlast on the final byte.
//   m_* carries one result transaction per frame, issued for the byte marked s_tlast;
//   other bytes produce nothing. m_tuser holds the status code.
//   cfg_we / cfg_wdata set ethernet_present (reset 1); write only while idle.
// Timing:
//   A byte is registered on acceptance and parsed from that input register; the result
//   of a final byte is then registered in the output register and presented on m_*.
//   One byte per cycle is sustained while no result is blocked, including across frame boundaries:
//   the next frame's bytes are taken while a result waits in the output register.
// Stall:
//   If the output register is still full when another final byte reaches the
//   parse stage, that byte waits and s_tready drops until m_tready frees the slot.
// Reset:
//   arst_n clears both valid flags, the header state and the byte offset, and
//   sets ethernet_present to 1.
module ipv4_l4_header_extractor_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [iphx_pkg::TDATA_W-1:0] m_tdata,
	                                // dst_mac, src_mac, src_ip, dst_ip, ip_ident, protocol,
	                                // port_pair, tcp_seq, tcp_ack, tcp_flags, payload_len
	output logic [2:0]   m_tuser,   // status
	input  logic         cfg_we,
	input  logic         cfg_wdata  // ethernet_present
);

	logic            eth_q;
	logic            valid_s1, last_s1;
	logic [7:0]      data_s1;
	logic            adv;
	logic            mvalid_q;
	iphx_pkg::res_t  res, res_q;

	assign adv = valid_s1 && (!last_s1 || !mvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eth_q <= 1'b1;
		else if (cfg_we)
			eth_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	iphx_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.eth_present(eth_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (adv && last_s1) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			res_q <= res;
	end

	assign m_tvalid = mvalid_q;
	assign m_tuser = res_q.status;
	assign m_tdata = {res_q.payload_len, res_q.tcp_flags, res_q.tcp_ack, res_q.tcp_seq,
		res_q.port_pair, res_q.protocol, res_q.ip_ident, res_q.dst_ip, res_q.src_ip,
		res_q.src_mac, res_q.dst_mac};

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> m_tvalid)
		else $error("final byte did not produce a result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && mvalid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_ports_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != iphx_pkg::ST_OK) |-> (m_tdata[215:184] == 32'd0
		&& m_tdata[303:288] == 16'd0))
		else $error("ports or payload length set on a failed frame");

	a_tcp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[183:176] != iphx_pkg::PROTO_TCP) |-> (m_tdata[287:216] == 72'd0))
		else $error("TCP fields set on a non-TCP frame");

endmodule

@@ tb/sv/ipv4_l4_header_extractor_unit_tb.sv @@
// Testbench for ipv4_l4_header_extractor_unit: drives frames as byte streams, with and
// without the Ethernet header, and checks every header result against an in-bench parser.
// Depends on iphx_pkg and the extractor RTL.
module ipv4_l4_header_extractor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iphx_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	class hdr_tracker;
		bit        eth_on = 1'b1;
		bit [6:0]  offs;
		bit [47:0] dmac, smac;
		bit [31:0] sip, dip, ports, seq, ack;
		bit [15:0] ident, tot_len, udp_len;
		bit [7:0]  proto, flags;
		bit [3:0]  ihl, doff;
		res_t      awaited_hdrs[$];
		int        mismatches;
		int        results_seen;

		function void clear_frame();
			offs = '0; dmac = '0; smac = '0; sip = '0; dip = '0; ports = '0; seq = '0;
			ack = '0; ident = '0; tot_len = '0; udp_len = '0; proto = '0; flags = '0;
			ihl = '0; doff = '0;
		endfunction

		function new();
			clear_frame();
		endfunction

		// one accepted byte; a final byte queues the header it completes
		function void take_byte(bit [7:0] b, bit last);
			int p, eth, q, lim, r, len, iplen, ihl_b, l4len, sub;
			res_t e;
			bit macs, ipf, prt, tcp;
			bit [2:0] st;
			bit [15:0] pay;
			p = offs;
			eth = eth_on ? int'(ETH_HDR_BYTES) : 0;
			if (eth != 0 && p < eth) begin
				if (p < 6) dmac = {dmac[39:0], b};
				else if (p < 12) smac = {smac[39:0], b};
			end else begin
				q = p - eth;
				if (q == 0) ihl = b[3:0];
				else if (q == 2 || q == 3) tot_len = {tot_len[7:0], b};
				else if (q == 4 || q == 5) ident = {ident[7:0], b};
				else if (q == 9) proto = b;
				else if (q >= 12 && q < 16) sip = {sip[23:0], b};
				else if (q >= 16 && q < 20) dip = {dip[23:0], b};
				lim = ihl * 4;
				if (q >= lim) begin
					r = q - lim;
					if (r < 4) ports = {ports[23:0], b};
					else if (r < 8) seq = {seq[23:0], b};
					else if (r < 12) ack = {ack[23:0], b};
					else if (r == 12) doff = b[7:4];
					else if (r == 13) flags = b;
					if (r == 4 || r == 5) udp_len = {udp_len[7:0], b};
				end
			end
			if (offs != 7'd127) offs = offs + 7'd1;
			if (!last) return;

			macs = 1'b0; ipf = 1'b0; prt = 1'b0; tcp = 1'b0; pay = '0;
			len = p + 1;
			ihl_b = ihl * 4;
			if (len < eth) begin
				st = ST_SHORT_ETH;
			end else begin
				macs = (eth != 0);
				iplen = len - eth;
				if (iplen < int'(IP_MIN_BYTES)) st = ST_SHORT_IP;
				else if (iplen < ihl_b) st = ST_SHORT_OPT;
				else begin
					ipf = 1'b1;
					l4len = iplen - ihl_b;
					if (proto == PROTO_TCP) begin
						if (l4len < int'(TCP_MIN_BYTES)) st = ST_SHORT_L4;
						else begin
							st = ST_OK; prt = 1'b1; tcp = 1'b1;
							sub = ihl_b + doff * 4;
							pay = (int'(tot_len) > sub) ? 16'(int'(tot_len) - sub) : 16'd0;
						end
					end else if (proto == PROTO_UDP) begin
						if (l4len < int'(UDP_HDR_BYTES)) st = ST_SHORT_L4;
						else begin
							st = ST_OK; prt = 1'b1;
							pay = (udp_len > 16'(UDP_HDR_BYTES)) ?
							      udp_len - 16'(UDP_HDR_BYTES) : 16'd0;
						end
					end else begin
						st = ST_NOT_L4;
					end
				end
			end
			e = '0;
			e.status = st;
			if (macs) begin e.dst_mac = dmac; e.src_mac = smac; end
			if (ipf) begin
				e.src_ip = sip; e.dst_ip = dip; e.ip_ident = ident; e.protocol = proto;
			end
			if (prt) begin e.port_pair = ports; e.payload_len = pay; end
			if (tcp) begin e.tcp_seq = seq; e.tcp_ack = ack; e.tcp_flags = flags; end
			awaited_hdrs.push_back(e);
			clear_frame();
		endfunction

		task report_mismatch(string fld, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH result %0d %s: got %h want %h", results_seen, fld, got, want);
			mismatches++;
		endtask

		task check_header(logic [303:0] d, logic [2:0] st);
			res_t w;
			if (awaited_hdrs.size() == 0) begin
				report_mismatch("unexpected result", {61'd0, st}, 64'd0);
				return;
			end
			w = awaited_hdrs.pop_front();
			if (st !== w.status) report_mismatch("status", st, w.status);
			if (d[47:0] !== w.dst_mac) report_mismatch("dst_mac", d[47:0], w.dst_mac);
			if (d[95:48] !== w.src_mac) report_mismatch("src_mac", d[95:48], w.src_mac);
			if (d[127:96] !== w.src_ip) report_mismatch("src_ip", d[127:96], w.src_ip);
			if (d[159:128] !== w.dst_ip) report_mismatch("dst_ip", d[159:128], w.dst_ip);
			if (d[175:160] !== w.ip_ident) report_mismatch("ip_ident", d[175:160], w.ip_ident);
			if (d[183:176] !== w.protocol) report_mismatch("protocol", d[183:176], w.protocol);
			if (d[215:184] !== w.port_pair) report_mismatch("port_pair", d[215:184], w.port_pair);
			if (d[247:216] !== w.tcp_seq) report_mismatch("tcp_seq", d[247:216], w.tcp_seq);
			if (d[279:248] !== w.tcp_ack) report_mismatch("tcp_ack", d[279:248], w.tcp_ack);
			if (d[287:280] !== w.tcp_flags) report_mismatch("tcp_flags", d[287:280], w.tcp_flags);
			if (d[303:288] !== w.payload_len)
				report_mismatch("payload_len", d[303:288], w.payload_len);
			results_seen++;
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [303:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_wdata = 1'b1;

	hdr_tracker book;
	int  cycles = 0;
	int  hold = 0;
	int  bytes_sent = 0;
	int  frames_sent = 0;
	bit  quiet = 1'b0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;

	ipv4_l4_header_extractor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5ns clk = ~clk;

	always @(negedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
			m_tready <= 1'b0;
		end else if (!quiet && rx_idle && $urandom_range(0, 4) == 0) begin
			hold <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && m_tvalid && m_tready)
			book.check_header(m_tdata, m_tuser);
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task send_byte(bit [7:0] b, bit last);
		int n;
		if (tx_idle && !quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		book.take_byte(b, last);
		bytes_sent++;
		if (last) frames_sent++;
	endtask

	task send_bytes(bit [7:0] fr[$]);
		foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
	endtask

	task set_ethernet(bit v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (book.awaited_hdrs.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		book.eth_on = v;
	endtask

	// mostly well-formed TCP/UDP frames, some other protocols, odd IHL and truncations
	task send_frame();
		bit [7:0]  fr[$];
		bit [7:0]  prot;
		bit [15:0] tot;
		int        ihl, hb, l4hdr, paylen, sel;
		fr = {};
		tx_idle = ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		if (book.eth_on) repeat (14) fr.push_back(8'($urandom));
		sel = $urandom_range(0, 9);
		prot = (sel < 5) ? PROTO_TCP : (sel < 8) ? PROTO_UDP : 8'($urandom);
		sel = $urandom_range(0, 9);
		ihl = (sel < 6) ? 5 : (sel < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
		hb = (ihl < 5) ? 20 : ihl * 4;
		l4hdr = (prot == PROTO_TCP) ? 20 : (prot == PROTO_UDP) ? 8 : $urandom_range(0, 12);
		paylen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 16);
		tot = 16'(hb + l4hdr + paylen);
		if ($urandom_range(0, 4) == 0) tot = 16'($urandom);

		fr.push_back({($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)});
		fr.push_back(8'($urandom));
		fr.push_back(tot[15:8]);
		fr.push_back(tot[7:0]);
		repeat (5) fr.push_back(8'($urandom));
		fr.push_back(prot);
		repeat (hb - 10) fr.push_back(8'($urandom));

		if (prot == PROTO_TCP) begin
			repeat (12) fr.push_back(8'($urandom));
			fr.push_back({($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5, 4'($urandom)});
			repeat (7) fr.push_back(8'($urandom));
		end else if (prot == PROTO_UDP) begin
			repeat (4) fr.push_back(8'($urandom));
			tot = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(8 + paylen);
			fr.push_back(tot[15:8]);
			fr.push_back(tot[7:0]);
			repeat (2) fr.push_back(8'($urandom));
		end else begin
			repeat (l4hdr) fr.push_back(8'($urandom));
		end
		repeat (paylen) fr.push_back(8'($urandom));

		if ($urandom_range(0, 3) == 0)
			fr = fr[0:$urandom_range(0, fr.size() - 1)];
		send_bytes(fr);
	endtask

	initial begin
		bit [7:0] fr[$];
		book = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// single-byte frames at both byte extremes, then a bare Ethernet header of ones
		send_bytes('{8'hFF});
		send_bytes('{8'h00});
		fr = {};
		repeat (14) fr.push_back(8'hFF);
		send_bytes(fr);

		for (int ph = 0; ph < 6; ph++) begin
			set_ethernet((ph < 3) ? ph[0] : 1'($urandom));
			quiet = (ph == 5);
			while (bytes_sent < (ph + 1) * 260 || (ph == 5 && book.results_seen < 48))
				send_frame();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (book.awaited_hdrs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d frames (%0d bytes) through six Ethernet-header settings;",
		         frames_sent, bytes_sent);
		$display("%0d header results compared, %0d mismatches.", book.results_seen,
		         book.mismatches);
		if (book.mismatches == 0 && book.awaited_hdrs.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
